### hw/rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, entry type, codes and cell control.
`default_nettype none

package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int PRIO_BITS    = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int FILL_BITS    = 5;
    localparam int IDX_BITS     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [0:0] {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [PRIO_BITS-1:0]    prio;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry ins;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/spq_if.sv
// Valid/ready channel interfaces for requests and results of the priority queue.
`default_nettype none

interface spq_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  cmd;
    logic [31:0] prio;
    logic [31:0] payload;

    modport source (output valid, output cmd, output prio, output payload, input ready);
    modport sink   (input valid, input cmd, input prio, input payload, output ready);
endinterface

interface spq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] head_prio;
    logic [31:0] head_payload;
    logic        is_empty;
    logic [4:0]  fill;

    modport source (output valid, output status, output head_prio, output head_payload,
                    output is_empty, output fill, input ready);
    modport sink   (input valid, input status, input head_prio, input head_payload,
                    input is_empty, input fill, output ready);
endinterface

`default_nettype wire

### hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: request decode, cell chain, result register.
//
// Usage:
//   i_req carries requests: cmd 0 pushes (prio, payload), cmd 1 pops the head.
//   o_rsp carries one result per request: status, head entry after the request,
//   is_empty and fill. Lower prio is served first; equal prio leaves in push order.
//   The result is registered in the cycle after the request is taken.
//   Throughput is one request per cycle: every slot compares against the
//   pushed priority and takes its own value, its left neighbor's or the new
//   entry in the same cycle, and a pop moves every slot one step toward the head.
//   A push into a full queue is dropped with status 1; a pop on an empty queue
//   leaves the queue unchanged with status 2. Head fields read zero when empty.
//   Reset empties the queue (fill count cleared) and drops any pending result;
//   slot contents are not cleared and are never shown.
//   When the receiver stalls, the result holds in the output register and
//   i_req.ready stays low until it is taken; a new request is taken in the
//   same cycle that the waiting result leaves.
`default_nettype none

module sorted_priority_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spq_req_if.sink     i_req,
    spq_rsp_if.source   o_rsp
);

    localparam int D = spq_pkg::DEPTH;

    logic [spq_pkg::CNT_BITS-1:0] r_count;
    logic [spq_pkg::CNT_BITS-1:0] n_count;

    logic                         r_out_valid;
    spq_pkg::t_status             r_status;
    logic [31:0]                  r_head_prio;
    logic [31:0]                  r_head_payload;
    logic                         r_is_empty;
    logic [spq_pkg::FILL_BITS-1:0] r_fill;

    logic                         w_take;
    logic                         w_full;
    logic                         w_empty;
    spq_pkg::t_status             w_status;
    spq_pkg::t_cell_ctl           w_ctl;

    spq_pkg::t_entry              w_data [D];
    spq_pkg::t_entry              w_next [D];
    logic                         w_keep [D];
    logic                         w_occ  [D];

    // Handshake: take a request whenever the result register is free or draining
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_take      = i_req.valid && i_req.ready;

    assign w_full  = (r_count == spq_pkg::CNT_BITS'(D));
    assign w_empty = (r_count == '0);

    // Request decode
    always_comb begin
        w_ctl.ins.prio    = i_req.prio[spq_pkg::PRIO_BITS-1:0];
        w_ctl.ins.payload = i_req.payload[spq_pkg::PAYLOAD_BITS-1:0];
        w_ctl.push        = 1'b0;
        w_ctl.pop         = 1'b0;
        w_status          = spq_pkg::ST_OK;
        n_count           = r_count;
        if (i_req.cmd == spq_pkg::CMD_PUSH) begin
            if (w_full) begin
                w_status = spq_pkg::ST_FULL;
            end else begin
                w_ctl.push = w_take;
                n_count    = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                w_status = spq_pkg::ST_EMPTY;
            end else begin
                w_ctl.pop = w_take;
                n_count   = r_count - 1'b1;
            end
        end
    end

    // Chain of slots, head at index 0
    for (genvar i = 0; i < D; i++) begin : g_cell
        assign w_occ[i] = (spq_pkg::CNT_BITS'(i) < r_count);

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occ        (w_occ[i]),
            .i_left_keep  ((i == 0) ? 1'b1 : w_keep[(i == 0) ? 0 : i - 1]),
            .i_left_data  ((i == 0) ? w_ctl.ins : w_data[(i == 0) ? 0 : i - 1]),
            .i_right_data ((i == D - 1) ? w_data[i] : w_data[(i == D - 1) ? i : i + 1]),
            .o_data       (w_data[i]),
            .o_next       (w_next[i]),
            .o_keep       (w_keep[i])
        );
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_take) begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status   <= w_status;
            r_is_empty <= (n_count == '0);
            r_fill     <= spq_pkg::FILL_BITS'(n_count);
            if (n_count == '0) begin
                r_head_prio    <= '0;
                r_head_payload <= '0;
            end else begin
                r_head_prio    <= 32'(w_next[0].prio);
                r_head_payload <= 32'(w_next[0].payload);
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.head_prio    = r_head_prio;
    assign o_rsp.head_payload = r_head_payload;
    assign o_rsp.is_empty     = r_is_empty;
    assign o_rsp.fill         = r_fill;

endmodule

`default_nettype wire

### hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, inserts or shifts from its neighbors.
`default_nettype none

module spq_cell (
    input  wire logic               i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_occ,        // slot holds a live entry
    input  wire logic               i_left_keep,  // left neighbor stays in place
    input  wire spq_pkg::t_entry    i_left_data,
    input  wire spq_pkg::t_entry    i_right_data,
    output spq_pkg::t_entry         o_data,
    output spq_pkg::t_entry         o_next,
    output logic                    o_keep
);

    spq_pkg::t_entry r_data;
    spq_pkg::t_entry n_data;

    // Entry stays when it sorts at or ahead of the pushed one (ties stay first)
    assign o_keep = i_occ && (r_data.prio <= i_ctl.ins.prio);

    // Next slot content
    always_comb begin
        n_data = r_data;
        if (i_ctl.push) begin
            if (!o_keep) begin
                n_data = i_left_keep ? i_ctl.ins : i_left_data;
            end
        end else if (i_ctl.pop) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_next = n_data;

endmodule

`default_nettype wire

### hw/rtl/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_status,
    input wire logic [31:0] i_head_prio,
    input wire logic [31:0] i_head_payload,
    input wire logic        i_is_empty,
    input wire logic [4:0]  i_fill
);

    // No result is pending right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Empty flag, count and head fields agree
    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_empty == (i_fill == 5'd0)) &&
                        (!i_is_empty || (i_head_prio == 32'd0 && i_head_payload == 32'd0)))
        else $error("empty flag inconsistent with fill or head");

    // A failed pop means the queue is empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == spq_pkg::ST_EMPTY |-> i_is_empty)
        else $error("pop error reported on non-empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_head_prio    (o_rsp.head_prio),
    .i_head_payload (o_rsp.head_payload),
    .i_is_empty     (o_rsp.is_empty),
    .i_fill         (o_rsp.fill)
);

`default_nettype wire
